// ===== sv/btlv_pkg.sv =====
// Shared types and constants for the BER-TLV stream parser.
// No dependencies; the cell, parse, emit, top-level and bench files import this package.
`default_nettype none

package btlv_pkg;

	localparam int unsigned MAX_DEPTH_DEF = 8;
	localparam int unsigned TAG_W         = 24;
	localparam int unsigned LEN_W         = 16;
	localparam int unsigned NEST_W        = 4;

	// results per byte are capped at this count
	localparam logic [3:0] MAX_RESULTS = 4'd9;
	// low five bits of a first tag byte that announce a longer tag
	localparam logic [4:0] TAG_EXT     = 5'h1f;

	typedef enum logic [1:0] {
		KIND_HDR = 2'd0,
		KIND_VAL = 2'd1,
		KIND_END = 2'd2,
		KIND_OVR = 2'd3
	} kind_t;

	// carried upward through the row of stack cells
	typedef struct packed {
		logic found;   // some cell at or below here reached zero
		logic dirty;   // an open cell above the first zero is still nonzero
	} link_t;

	typedef struct packed {
		logic open;
		logic first;   // this cell is the outermost one at zero
	} cell_stat_t;

	typedef struct packed {
		logic               valid;
		kind_t              kind;
		logic [TAG_W-1:0]   tag_value;
		logic [1:0]         tag_class;
		logic               is_constructed;
		logic [LEN_W-1:0]   value_length;
		logic [7:0]         value_byte;
	} prim_t;

	typedef struct packed {
		prim_t prim;
		logic  push;     // a template opens; its length is prim.value_length
		logic  at_tag;   // parser expects a tag after this byte
	} parse_out_t;

	typedef struct packed {
		kind_t              kind;
		logic [TAG_W-1:0]   tag_value;
		logic [1:0]         tag_class;
		logic               is_constructed;
		logic [LEN_W-1:0]   value_length;
		logic [7:0]         value_byte;
		logic [NEST_W-1:0]  nest_level;
		logic               last_result;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/btlv_in_if.sv =====
// Byte input channel of the BER-TLV parser.
// Depends on nothing.
`default_nettype none

interface btlv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/btlv_out_if.sv =====
// Result channel of the BER-TLV parser.
// Field widths come from btlv_pkg.
`default_nettype none

interface btlv_out_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   kind;
	logic [btlv_pkg::TAG_W-1:0]   tag_value;
	logic [1:0]                   tag_class;
	logic                         is_constructed;
	logic [btlv_pkg::LEN_W-1:0]   value_length;
	logic [7:0]                   value_byte;
	logic [btlv_pkg::NEST_W-1:0]  nest_level;
	logic                         last_result;

	modport source (output valid, output kind, output tag_value, output tag_class,
		output is_constructed, output value_length, output value_byte,
		output nest_level, output last_result, input ready);
	modport sink (input valid, input kind, input tag_value, input tag_class,
		input is_constructed, input value_length, input value_byte,
		input nest_level, input last_result, output ready);
endinterface

`default_nettype wire

// ===== sv/btlv_cfg_if.sv =====
// Configuration write channel of the BER-TLV parser (skip_padding register).
// Depends on nothing.
`default_nettype none

interface btlv_cfg_if;
	logic valid;
	logic ready;
	logic skip_padding;

	modport source (output valid, output skip_padding, input ready);
	modport sink   (input valid, input skip_padding, output ready);
endinterface

`default_nettype wire

// ===== sv/btlv_cell.sv =====
// One level of the template stack: an open flag and a length down-counter.
// Depends on btlv_pkg; instantiated in a row by ber_tlv_stream_parser.
`default_nettype none

module btlv_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic                       push_here,
	input  wire logic [btlv_pkg::LEN_W-1:0] push_len,
	input  wire btlv_pkg::link_t            lin,
	output btlv_pkg::link_t                 lout,
	output btlv_pkg::cell_stat_t            stat
);
	import btlv_pkg::*;

	logic             open_q;
	logic [LEN_W-1:0] cnt_q;
	logic             open_n;
	logic [LEN_W-1:0] cnt_n;
	logic             zero;

	always_comb begin
		open_n = open_q | push_here;
		// a level opened by this byte starts at its full length
		if (push_here) begin
			cnt_n = push_len;
		end else if (cnt_q != '0) begin
			cnt_n = cnt_q - LEN_W'(1);
		end else begin
			cnt_n = cnt_q;
		end
		zero       = open_n && (cnt_n == '0);
		lout.found = lin.found | zero;
		lout.dirty = lin.dirty | (lin.found & open_n & ~zero);
		stat.open  = open_q;
		stat.first = zero & ~lin.found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (step) begin
			// everything from the outermost zero level inward pops
			open_q <= open_n & ~lout.found;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			cnt_q <= cnt_n;
		end
	end

endmodule

`default_nettype wire

// ===== sv/btlv_parse.sv =====
// Tag/length/value byte parser: phase sequencer and header accumulators.
// Depends on btlv_pkg; instantiated by ber_tlv_stream_parser.
`default_nettype none

module btlv_parse (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic            abort,
	input  wire logic            skip_padding,
	input  wire logic            open_full,
	input  wire logic [7:0]      data_byte,
	output btlv_pkg::parse_out_t po
);
	import btlv_pkg::*;

	typedef enum logic [4:0] {
		PH_TAG      = 5'b00001,
		PH_TAG_MORE = 5'b00010,
		PH_LEN      = 5'b00100,
		PH_LEN_MORE = 5'b01000,
		PH_VALUE    = 5'b10000
	} phase_t;

	phase_t           phase_q, phase_n;
	logic [TAG_W-1:0] tag_q, tag_n;
	logic [1:0]       tcnt_q, tcnt_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic [1:0]       lbl_q, lbl_n;
	logic [LEN_W-1:0] vbl_q, vbl_n;
	logic             fin;
	logic [7:0]       first_byte;

	always_comb begin
		case (tcnt_q)
			2'd2: first_byte = tag_q[15:8];
			2'd3: first_byte = tag_q[23:16];
			default: first_byte = tag_q[7:0];
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		tag_n   = tag_q;
		tcnt_n  = tcnt_q;
		len_n   = len_q;
		lbl_n   = lbl_q;
		vbl_n   = vbl_q;
		fin     = 1'b0;
		po      = '0;

		case (phase_q)
			PH_TAG: begin
				if (!(data_byte == 8'h00 && skip_padding)) begin
					tag_n   = {16'h0000, data_byte};
					tcnt_n  = 2'd1;
					len_n   = '0;
					phase_n = (data_byte[4:0] == TAG_EXT) ? PH_TAG_MORE : PH_LEN;
				end
			end
			PH_TAG_MORE: begin
				tag_n   = {tag_q[15:0], data_byte};
				tcnt_n  = tcnt_q + 2'd1;
				phase_n = (tcnt_n == 2'd2 && data_byte[7]) ? PH_TAG_MORE : PH_LEN;
			end
			PH_LEN: begin
				if (data_byte[7] && data_byte[1:0] != 2'b00) begin
					lbl_n   = data_byte[0] ? 2'd1 : 2'd2;
					len_n   = '0;
					phase_n = PH_LEN_MORE;
				end else begin
					len_n = {8'h00, data_byte};
					fin   = 1'b1;
				end
			end
			PH_LEN_MORE: begin
				len_n = {len_q[7:0], data_byte};
				if (lbl_q != 2'd0) begin
					lbl_n = lbl_q - 2'd1;
				end
				fin = (lbl_n == 2'd0);
			end
			PH_VALUE: begin
				po.prim.valid      = 1'b1;
				po.prim.kind       = KIND_VAL;
				po.prim.value_byte = data_byte;
				if (vbl_q != '0) begin
					vbl_n = vbl_q - LEN_W'(1);
				end
				if (vbl_n == '0) begin
					phase_n = PH_TAG;
				end
			end
			default: begin
				phase_n = PH_TAG;
			end
		endcase

		if (fin) begin
			po.prim.valid          = 1'b1;
			po.prim.tag_value      = tag_q;
			po.prim.tag_class      = first_byte[7:6];
			po.prim.is_constructed = first_byte[5];
			po.prim.value_length   = len_n;
			if (first_byte[5] && !open_full) begin
				po.prim.kind = KIND_HDR;
				po.push      = 1'b1;
				phase_n      = PH_TAG;
			end else begin
				// constructed with the stack full: flagged, body read as value bytes
				po.prim.kind = first_byte[5] ? KIND_OVR : KIND_HDR;
				vbl_n        = len_n;
				phase_n      = (len_n != '0) ? PH_VALUE : PH_TAG;
			end
		end

		po.at_tag = (phase_n == PH_TAG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			tag_q   <= '0;
			tcnt_q  <= '0;
			len_q   <= '0;
			lbl_q   <= '0;
			vbl_q   <= '0;
		end else if (step) begin
			if (abort) begin
				phase_q <= PH_TAG;
				tag_q   <= '0;
				tcnt_q  <= '0;
				len_q   <= '0;
				lbl_q   <= '0;
				vbl_q   <= '0;
			end else begin
				phase_q <= phase_n;
				tag_q   <= tag_n;
				tcnt_q  <= tcnt_n;
				len_q   <= len_n;
				lbl_q   <= lbl_n;
				vbl_q   <= vbl_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/btlv_emit.sv =====
// Result sequencer: holds one byte's results and plays them out one per beat
// through the output register. Depends on btlv_pkg.
`default_nettype none

module btlv_emit #(
	parameter int unsigned MAX_DEPTH = btlv_pkg::MAX_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               load,
	input  wire btlv_pkg::prim_t                    prim,
	input  wire logic [$clog2(MAX_DEPTH+1)-1:0]     prim_lvl,
	input  wire btlv_pkg::kind_t                    tail_kind,
	input  wire logic [3:0]                         tail_cnt,
	input  wire logic [$clog2(MAX_DEPTH+1)-1:0]     tail_lvl,
	input  wire logic                               out_ready,
	output logic                                    out_valid,
	output btlv_pkg::res_t                          res,
	output logic                                    can_take
);
	import btlv_pkg::*;

	localparam int unsigned LW = $clog2(MAX_DEPTH + 1);

	logic          pvalid_q;
	prim_t         prim_q;
	logic [LW-1:0] prim_lvl_q;
	kind_t         tail_kind_q;
	logic [3:0]    tail_cnt_q;
	logic [LW-1:0] tail_lvl_q;
	logic          out_valid_q;
	res_t          res_q;
	res_t          nxt;
	logic          free;
	logic          have;
	logic          one_left;

	assign free     = !out_valid_q || out_ready;
	assign have     = pvalid_q || (tail_cnt_q != 4'd0);
	assign one_left = pvalid_q ? (tail_cnt_q == 4'd0) : (tail_cnt_q == 4'd1);
	// a new byte may come in on the beat that drains the last held result
	assign can_take = !have || (one_left && free);

	always_comb begin
		nxt = '0;
		if (pvalid_q) begin
			nxt.kind           = prim_q.kind;
			nxt.tag_value      = prim_q.tag_value;
			nxt.tag_class      = prim_q.tag_class;
			nxt.is_constructed = prim_q.is_constructed;
			nxt.value_length   = prim_q.value_length;
			nxt.value_byte     = prim_q.value_byte;
			nxt.nest_level     = NEST_W'(prim_lvl_q);
			nxt.last_result    = (tail_cnt_q == 4'd0);
		end else begin
			nxt.kind        = tail_kind_q;
			nxt.nest_level  = NEST_W'(tail_lvl_q);
			nxt.last_result = (tail_cnt_q == 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pvalid_q    <= 1'b0;
			tail_cnt_q  <= 4'd0;
		end else begin
			if (free) begin
				out_valid_q <= have;
			end
			if (load) begin
				pvalid_q   <= prim.valid;
				tail_cnt_q <= tail_cnt;
			end else if (free && have) begin
				if (pvalid_q) begin
					pvalid_q <= 1'b0;
				end else begin
					tail_cnt_q <= tail_cnt_q - 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free && have) begin
			res_q <= nxt;
		end
		if (load) begin
			prim_q      <= prim;
			prim_lvl_q  <= prim_lvl;
			tail_kind_q <= tail_kind;
			tail_lvl_q  <= tail_lvl;
		end else if (free && have && !pvalid_q) begin
			// template ends walk outward one level per beat
			tail_lvl_q <= tail_lvl_q - LW'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== sv/ber_tlv_stream_parser.sv =====
// BER-TLV stream parser, top level. A byte's results are held in the emit sequencer
// and registered into the single output register, which plays them out one per
// beat. A byte with more than one result holds the input until only its last
// result is left to go; a stalled output also holds the input.
// Reset (arst_n low) empties the template stack, returns the parser to a tag
// boundary and sets skip_padding to 1. Depends on btlv_pkg, cells, parse, emit.
`default_nettype none

module ber_tlv_stream_parser #(
	parameter int unsigned MAX_DEPTH = btlv_pkg::MAX_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	btlv_in_if.sink    stream,
	btlv_out_if.source result,
	btlv_cfg_if.sink   cfg
);
	import btlv_pkg::*;

	localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
	localparam int unsigned EW = (LW > 4) ? LW : 4;

	logic           skip_q;
	logic [LW-1:0]  open_q;
	logic           step;
	logic           can_take;
	logic           open_full;
	parse_out_t     po;
	link_t          links [MAX_DEPTH+1];
	cell_stat_t     stat  [MAX_DEPTH];
	logic [MAX_DEPTH-1:0] open_vec;
	logic [LW-1:0]  z;
	logic [LW-1:0]  open_n;
	logic [LW-1:0]  ends;
	logic [3:0]     cap;
	logic           found;
	logic           clean;
	logic           ovr;
	kind_t          tail_kind;
	logic [3:0]     tail_cnt;
	logic [LW-1:0]  tail_lvl;
	logic           out_valid;
	res_t           res;

	assign cfg.ready    = 1'b1;
	assign stream.ready = can_take;
	assign step         = stream.valid && can_take;
	assign open_full    = (open_q == LW'(MAX_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b1;
		end else if (cfg.valid) begin
			skip_q <= cfg.skip_padding;
		end
	end

	btlv_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.abort        (ovr),
		.skip_padding (skip_q),
		.open_full    (open_full),
		.data_byte    (stream.data_byte),
		.po           (po)
	);

	assign links[0] = '0;

	for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
		btlv_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (step),
			.push_here (po.push && (open_q == LW'(g))),
			.push_len  (po.prim.value_length),
			.lin       (links[g]),
			.lout      (links[g+1]),
			.stat      (stat[g])
		);
		assign open_vec[g] = stat[g].open;
	end

	always_comb begin
		z = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (stat[i].first) begin
				z = z | LW'(i);
			end
		end
	end

	assign found  = links[MAX_DEPTH].found;
	assign clean  = !links[MAX_DEPTH].dirty && po.at_tag;
	// a template ran out inside an unfinished element
	assign ovr    = found && !clean;
	assign open_n = open_q + LW'(po.push);
	assign ends   = open_n - z;
	assign cap    = MAX_RESULTS - {3'b000, po.prim.valid};

	always_comb begin
		tail_kind = KIND_END;
		tail_cnt  = 4'd0;
		tail_lvl  = open_n - LW'(1);
		if (ovr) begin
			tail_kind = KIND_OVR;
			tail_cnt  = 4'd1;
			tail_lvl  = z;
		end else if (found) begin
			tail_cnt = (EW'(ends) > EW'(cap)) ? cap : 4'(ends);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (step) begin
			open_q <= found ? z : open_n;
		end
	end

	btlv_emit #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.prim      (po.prim),
		.prim_lvl  (open_q),
		.tail_kind (tail_kind),
		.tail_cnt  (tail_cnt),
		.tail_lvl  (tail_lvl),
		.out_ready (result.ready),
		.out_valid (out_valid),
		.res       (res),
		.can_take  (can_take)
	);

	assign result.valid          = out_valid;
	assign result.kind           = res.kind;
	assign result.tag_value      = res.tag_value;
	assign result.tag_class      = res.tag_class;
	assign result.is_constructed = res.is_constructed;
	assign result.value_length   = res.value_length;
	assign result.value_byte     = res.value_byte;
	assign result.nest_level     = res.nest_level;
	assign result.last_result    = res.last_result;

`ifndef SYNTH
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= LW'(MAX_DEPTH))
		else $error("open level count beyond stack depth");

	a_cells_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(open_vec) == int'(open_q))
		else $error("stack cell open flags disagree with level count");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		step && po.push |-> !open_full)
		else $error("template pushed onto a full stack");

	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.last_result |=> result.valid)
		else $error("gap inside the results of one byte");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_ber_tlv_stream_parser.sv =====
// Testbench for ber_tlv_stream_parser: directed TLV streams and random well-formed
// and broken streams under sender gaps and receiver stalls, checked beat by beat.
// Depends on btlv_pkg, btlv_in_if, btlv_out_if, btlv_cfg_if and the parser RTL.

module tb_ber_tlv_stream_parser;
	import btlv_pkg::*;

	localparam int NEST_DEPTH  = MAX_DEPTH_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYC  = 8;

	// parser phases
	localparam logic [2:0] ST_TAG      = 3'd0;
	localparam logic [2:0] ST_TAG_MORE = 3'd1;
	localparam logic [2:0] ST_LEN      = 3'd2;
	localparam logic [2:0] ST_LEN_MORE = 3'd3;
	localparam logic [2:0] ST_VALUE    = 3'd4;

	typedef logic [7:0] tlv_octets_t[$];

	logic clk;
	logic arst_n;

	btlv_in_if  byte_ch();
	btlv_out_if event_ch();
	btlv_cfg_if cfg_ch();

	ber_tlv_stream_parser #(.MAX_DEPTH(NEST_DEPTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (byte_ch),
		.result (event_ch),
		.cfg    (cfg_ch)
	);

	// parser shadow state
	logic        pad_skip;
	logic [2:0]  ps_phase;
	int unsigned tag_acc;
	int          tag_len;
	int unsigned len_acc;
	int          len_todo;
	int unsigned val_todo;
	int unsigned tmpl_left[NEST_DEPTH];
	int          open_cnt;

	res_t step_events[$];
	res_t tlv_events_due[$];

	int err_count;
	int send_idle_pct;
	int stall_pct;
	int ready_hold;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void reset_shadow();
		int i;
		pad_skip = 1'b1;
		ps_phase = ST_TAG;
		tag_acc  = 0;
		tag_len  = 0;
		len_acc  = 0;
		len_todo = 0;
		val_todo = 0;
		open_cnt = 0;
		for (i = 0; i < NEST_DEPTH; i++)
			tmpl_left[i] = 0;
	endfunction

	function automatic void push_event(kind_t k, int unsigned tag, int unsigned cls,
		int unsigned cons, int unsigned len, int unsigned vb, int lvl);
		res_t e;
		if (step_events.size() >= int'(MAX_RESULTS))
			return;
		e.kind           = k;
		e.tag_value      = 24'(tag);
		e.tag_class      = 2'(cls);
		e.is_constructed = 1'(cons);
		e.value_length   = 16'(len);
		e.value_byte     = 8'(vb);
		e.nest_level     = 4'(lvl);
		e.last_result    = 1'b0;
		step_events.push_back(e);
	endfunction

	function automatic void close_header();
		int          n;
		int unsigned lead, cls, cons;
		n    = (tag_len >= 1 && tag_len <= 3) ? tag_len : 1;
		lead = (tag_acc >> (8 * (n - 1))) & 32'hFF;
		cls  = lead >> 6;
		cons = (lead >> 5) & 1;
		if (cons != 0 && open_cnt < NEST_DEPTH) begin
			push_event(KIND_HDR, tag_acc, cls, cons, len_acc, 0, open_cnt);
			tmpl_left[open_cnt] = len_acc;
			open_cnt++;
			ps_phase = ST_TAG;
		end else begin
			// too deep: flagged, then carried as if primitive
			push_event(cons != 0 ? KIND_OVR : KIND_HDR, tag_acc, cls, cons, len_acc, 0,
				open_cnt);
			val_todo = len_acc;
			ps_phase = (len_acc != 0) ? ST_VALUE : ST_TAG;
		end
	endfunction

	// Works out every event one accepted byte causes and queues them.
	function automatic void parse_tlv_byte(logic [7:0] b);
		int i, z;
		bit found, clean;
		step_events.delete();
		for (i = 0; i < open_cnt; i++)
			if (tmpl_left[i] > 0)
				tmpl_left[i]--;

		case (ps_phase)
		ST_TAG: begin
			if (!(b == 8'h00 && pad_skip)) begin
				tag_acc  = b;
				tag_len  = 1;
				len_acc  = 0;
				ps_phase = (b[4:0] == TAG_EXT) ? ST_TAG_MORE : ST_LEN;
			end
		end
		ST_TAG_MORE: begin
			tag_acc = ((tag_acc << 8) | b) & 32'hFFFFFF;
			tag_len++;
			ps_phase = (tag_len == 2 && b[7]) ? ST_TAG_MORE : ST_LEN;
		end
		ST_LEN: begin
			if (b[7] && b[1:0] != 2'b00) begin
				len_todo = b[0] ? 1 : 2;
				len_acc  = 0;
				ps_phase = ST_LEN_MORE;
			end else begin
				len_acc = b;
				close_header();
			end
		end
		ST_LEN_MORE: begin
			len_acc = ((len_acc << 8) | b) & 32'hFFFF;
			if (len_todo > 0)
				len_todo--;
			if (len_todo == 0)
				close_header();
		end
		ST_VALUE: begin
			push_event(KIND_VAL, 0, 0, 0, 0, b, open_cnt);
			if (val_todo > 0)
				val_todo--;
			if (val_todo == 0)
				ps_phase = ST_TAG;
		end
		default: ps_phase = ST_TAG;
		endcase

		// outermost template that ran out decides end vs overrun
		found = 1'b0;
		z = 0;
		for (i = 0; i < open_cnt; i++)
			if (!found && tmpl_left[i] == 0) begin
				z = i;
				found = 1'b1;
			end
		if (found) begin
			clean = (ps_phase == ST_TAG);
			for (i = z; i < open_cnt; i++)
				if (tmpl_left[i] != 0)
					clean = 1'b0;
			if (clean) begin
				for (i = open_cnt; i > z; i--)
					push_event(KIND_END, 0, 0, 0, 0, 0, i - 1);
			end else begin
				push_event(KIND_OVR, 0, 0, 0, 0, 0, z);
				ps_phase = ST_TAG;
				tag_acc  = 0;
				tag_len  = 0;
				len_acc  = 0;
				len_todo = 0;
				val_todo = 0;
			end
			open_cnt = z;
		end

		if (step_events.size() > 0)
			step_events[step_events.size() - 1].last_result = 1'b1;
		while (step_events.size() > 0)
			tlv_events_due.push_back(step_events.pop_front());
	endfunction

	task automatic log_mismatch(input string msg);
		err_count++;
		$display("mismatch @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (event_ch.valid === 1'b1 && event_ch.ready === 1'b1) begin
			if (tlv_events_due.size() == 0) begin
				log_mismatch($sformatf("unexpected beat, kind %0d", event_ch.kind));
			end else begin
				want = tlv_events_due.pop_front();
				check_field("kind", 32'(event_ch.kind), 32'(want.kind));
				check_field("tag_value", 32'(event_ch.tag_value), 32'(want.tag_value));
				check_field("tag_class", 32'(event_ch.tag_class), 32'(want.tag_class));
				check_field("is_constructed", 32'(event_ch.is_constructed),
					32'(want.is_constructed));
				check_field("value_length", 32'(event_ch.value_length),
					32'(want.value_length));
				check_field("value_byte", 32'(event_ch.value_byte), 32'(want.value_byte));
				check_field("nest_level", 32'(event_ch.nest_level), 32'(want.nest_level));
				check_field("last_result", 32'(event_ch.last_result),
					32'(want.last_result));
			end
		end
	end

	// receiver: random stalls, or a forced hold-off while ready_hold runs down
	initial begin
		event_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				event_ch.ready = 1'b0;
				ready_hold--;
			end else begin
				event_ch.ready = ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// watchdog on cycles without any beat
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (event_ch.valid && event_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct)
			@(negedge clk);
		byte_ch.valid     = 1'b1;
		byte_ch.data_byte = b;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
		parse_tlv_byte(b);
		@(negedge clk);
		byte_ch.valid = 1'b0;
	endtask

	task automatic send_bytes(input tlv_octets_t s);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	task automatic wait_drained();
		while (tlv_events_due.size() != 0)
			@(negedge clk);
		// a byte with no event may still be in flight
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_skip_padding(input logic v);
		wait_drained();
		cfg_ch.valid        = 1'b1;
		cfg_ch.skip_padding = v;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		pad_skip = v;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic tlv_octets_t tag_octets(bit cons);
		tlv_octets_t t;
		int form;
		logic [7:0] lead, nxt;
		form = $urandom_range(0, 9);
		lead = 8'($urandom);
		lead[5] = cons;
		if (form < 6) begin
			if (lead[4:0] == TAG_EXT)
				lead[4:0] = 5'h1e;
			if (lead == 8'h00 && pad_skip)
				lead = 8'h02;
			t.push_back(lead);
		end else begin
			lead[4:0] = TAG_EXT;
			t.push_back(lead);
			nxt = 8'($urandom);
			nxt[7] = (form >= 8);
			t.push_back(nxt);
			if (form >= 8)
				t.push_back(8'($urandom));
		end
		return t;
	endfunction

	function automatic tlv_octets_t length_octets(int n);
		tlv_octets_t l;
		int form;
		form = $urandom_range(0, 9);
		if (n < 128 && form < 6) begin
			l.push_back(8'(n));
		end else if (n < 256 && form < 8) begin
			l.push_back(form[0] ? 8'h81 : 8'h83);
			l.push_back(8'(n));
		end else begin
			l.push_back(8'h82);
			l.push_back(8'(n >> 8));
			l.push_back(8'(n));
		end
		return l;
	endfunction

	// One element; chain forces a single-child nest past the stack depth.
	function automatic tlv_octets_t build_element(int depth, bit chain);
		tlv_octets_t body, hdr;
		int kids, n, i;
		if (depth <= NEST_DEPTH &&
			(chain || $urandom_range(0, 99) < (depth == 0 ? 45 : 25))) begin
			kids = chain ? 1 : $urandom_range(0, depth < 2 ? 3 : 1);
			for (i = 0; i < kids; i++) begin
				if (pad_skip && $urandom_range(0, 9) == 0)
					body.push_back(8'h00);
				body = {body, build_element(depth + 1, chain)};
			end
			n = body.size();
			// now and then a template length that does not match its content
			if ($urandom_range(0, 9) == 0)
				n += int'($urandom_range(0, 4)) - 2;
			if (n < 0)
				n = 0;
			hdr = {tag_octets(1'b1), length_octets(n)};
		end else begin
			n = $urandom_range(0, 6);
			if ($urandom_range(0, 19) == 0)
				n = $urandom_range(7, 40);
			for (i = 0; i < n; i++)
				body.push_back(8'($urandom));
			hdr = {tag_octets(1'b0), length_octets(n)};
		end
		return {hdr, body};
	endfunction

	task automatic send_random_stream(input int n_bytes);
		tlv_octets_t chunk;
		int sent, r;
		sent = 0;
		while (sent < n_bytes) begin
			r = $urandom_range(0, 99);
			chunk.delete();
			if (r < 10)
				repeat ($urandom_range(1, 4)) chunk.push_back(8'($urandom));
			else
				chunk = build_element(0, r < 14);
			if (pad_skip && r % 4 == 0)
				chunk.push_front(8'h00);
			send_bytes(chunk);
			sent += chunk.size();
		end
	endtask

	// padding, one/two/three byte tags, short and long length forms, empty elements
	task automatic test_tags_and_lengths();
		tlv_octets_t s;
		send_idle_pct = 20;
		stall_pct     = 20;
		s = {8'h00,
			8'hBF, 8'h81, 8'h85, 8'h00,
			8'h5F, 8'h20, 8'h81, 8'h01, 8'hFF,
			8'h04, 8'h82, 8'h00, 8'h02, 8'h00, 8'h80};
		send_bytes(s);
	endtask

	// nine nested templates; the ninth overflows and all eight close on one byte
	task automatic test_depth_overflow();
		tlv_octets_t s;
		int k;
		for (k = 0; k < NEST_DEPTH; k++) begin
			s.push_back(8'(8'h60 | k));
			s.push_back(8'(2 * NEST_DEPTH + 1 - 2 * k));
		end
		s.push_back(8'h30);
		s.push_back(8'h01);
		s.push_back(8'hA5);
		send_bytes(s);
	endtask

	// template runs out inside a primitive whose length byte is its own length
	task automatic test_boundary_overrun();
		tlv_octets_t s;
		s = {8'h20, 8'h03, 8'h04, 8'h84, 8'h5A};
		send_bytes(s);
	endtask

	task automatic test_padding_off();
		tlv_octets_t s;
		write_skip_padding(1'b0);
		s = {8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00};
		send_bytes(s);
	endtask

	// receiver holds off while bytes keep coming, so the input backs up
	task automatic test_back_pressure();
		write_skip_padding(1'b1);
		send_idle_pct = 0;
		stall_pct     = 0;
		ready_hold    = 150;
		send_random_stream(16);
	endtask

	// sender stops until every expected event is out, then resumes
	task automatic test_drain_pause();
		tlv_octets_t s;
		int k;
		send_idle_pct = 36;
		stall_pct     = 36;
		for (k = 0; k < 3; k++) begin
			s = build_element(0, 1'b0);
			send_bytes(s);
			while (tlv_events_due.size() != 0)
				@(negedge clk);
		end
	endtask

	task automatic test_random_traffic();
		write_skip_padding(1'b1);
		send_idle_pct = 0;
		stall_pct     = 0;
		send_random_stream(12);
		write_skip_padding(1'b0);
		send_idle_pct = 84;
		stall_pct     = 0;
		send_random_stream(12);
		write_skip_padding(1'b1);
		send_idle_pct = 0;
		stall_pct     = 84;
		send_random_stream(12);
		write_skip_padding(1'b0);
		send_idle_pct = 36;
		stall_pct     = 36;
		send_random_stream(12);
	endtask

	// maximum two-byte length; its value bytes are never completed
	task automatic test_long_lengths();
		tlv_octets_t s;
		write_skip_padding(1'b1);
		send_idle_pct = 20;
		stall_pct     = 20;
		s = {8'h9F, 8'h7F, 8'h82, 8'hFF, 8'hFF, 8'h3C, 8'hC3, 8'hFF, 8'h00};
		send_bytes(s);
	endtask

	initial begin
		arst_n              = 1'b0;
		byte_ch.valid       = 1'b0;
		byte_ch.data_byte   = 8'h00;
		cfg_ch.valid        = 1'b0;
		cfg_ch.skip_padding = 1'b1;
		err_count           = 0;
		send_idle_pct       = 0;
		stall_pct           = 0;
		ready_hold          = 0;
		reset_shadow();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_tags_and_lengths();
		test_depth_overflow();
		test_boundary_overrun();
		test_padding_off();
		test_back_pressure();
		test_drain_pause();
		test_random_traffic();
		test_long_lengths();

		while (tlv_events_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== ber_tlv_stream_parser.f =====
sv/btlv_pkg.sv
sv/btlv_in_if.sv
sv/btlv_out_if.sv
sv/btlv_cfg_if.sv
sv/btlv_cell.sv
sv/btlv_parse.sv
sv/btlv_emit.sv
sv/ber_tlv_stream_parser.sv
bench/tb_ber_tlv_stream_parser.sv
